/* rtl/sorted_insert_rank_list_defines.svh */
// Assertion macros for the sorted insert rank list.
// Both expect clk and rst_n in scope at the point of use.
`ifndef SORTED_INSERT_RANK_LIST_DEFINES_SVH
`define SORTED_INSERT_RANK_LIST_DEFINES_SVH
`ifndef SYNTHESIS
`define SIRL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SIRL_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SIRL_ASSERT(label, prop, msg)
`define SIRL_ASSERT_NEVER(label, cond, msg)
`endif
`endif

/* rtl/sirl_pkg.sv */
`timescale 1ns / 1ps
package sirl_pkg;

    localparam int DEF_CAPACITY = 64;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 8;
    localparam int TAG_W    = 16;
    localparam int STATUS_W = 2;
    localparam int RANK_W   = 7;
    localparam int ENTRY_W  = KEY_W + TAG_W;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_EMIT   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INS_WR,
        S_EMIT_RD,
        S_EMIT_OUT
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic cap;         // latch input fields
        logic srch_init;   // lo = 0, hi = count, idx = count
        logic rd_mid;      // read entry at search midpoint
        logic srch_step;   // narrow search window
        logic rd_prev;     // read entry idx - 1
        logic wr_shift;    // write read data to idx, idx--
        logic wr_ins;      // write new entry at lo, count++
        logic em_init;     // idx = 0
        logic rd_idx;      // read entry idx
        logic em_post;     // post entry result, idx++
        logic clr;         // count = 0
        logic post_ok;
        logic post_full;
        logic post_empty;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic empty;
        logic srch_fin;    // window closes after this step
        logic sh_more;     // idx > lo
        logic em_last;     // idx + 1 == count
    } dp_sts_t;

endpackage

/* rtl/sorted_insert_rank_list.sv */
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// input     start / busy              operation, sort_key, entry_tag
// result    out_strobe (one cycle)    status, out_key, out_tag, rank, last
//
// Clear, a dropped insert and an empty emit finish in the accept cycle (busy
// stays low); their result shows on the next cycle.
// An insert landing at p in a list of n entries makes s search steps (at most
// clog2(n+1)) and shifts n-p entries; the single memory read port serves one probe
// or one shifted entry at a time. Emit of n entries gives one result per read/post.
// Reset (rst_n, async, low) empties the list; memory keeps data. No result stalls.

`include "sorted_insert_rank_list_defines.svh"

module sorted_insert_rank_list #(
    parameter int CAPACITY = sirl_pkg::DEF_CAPACITY
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sirl_pkg::OP_W-1:0]     operation,
    input  logic [sirl_pkg::KEY_W-1:0]    sort_key,
    input  logic [sirl_pkg::TAG_W-1:0]    entry_tag,
    output logic                          out_strobe,
    output logic [sirl_pkg::STATUS_W-1:0] status,
    output logic [sirl_pkg::KEY_W-1:0]    out_key,
    output logic [sirl_pkg::TAG_W-1:0]    out_tag,
    output logic [sirl_pkg::RANK_W-1:0]   rank,
    output logic                          last
);

    sirl_pkg::dp_cmd_t cmd;   // controller commands
    sirl_pkg::dp_sts_t sts;   // datapath flags

    logic ins_full;   // insert transfer while the list is full
    logic err_out;    // result with a non-ok status
    logic full_out;   // result reporting a full list

    // Sequencer: search, shift, insert and emit walks.
    sirl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .sts       (sts),
        .busy      (busy),
        .cmd       (cmd)
    );

    // Entry memory, search window, walk index, rank tracker, result registers.
    sirl_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sort_key   (sort_key),
        .entry_tag  (entry_tag),
        .sts        (sts),
        .out_strobe (out_strobe),
        .status     (status),
        .out_key    (out_key),
        .out_tag    (out_tag),
        .rank       (rank),
        .last       (last)
    );

    assign ins_full = start && !busy && operation == sirl_pkg::OP_INSERT && sts.full;
    assign err_out  = out_strobe && status != sirl_pkg::ST_OK;
    assign full_out = out_strobe && status == sirl_pkg::ST_FULL;

    // busy only rises on an accepted transfer
    `SIRL_ASSERT(a_busy_from_start, $rose(busy) |-> $past(start), "busy rose without start")
    // a result that is not the last one belongs to an emit still in flight
    `SIRL_ASSERT_NEVER(a_mid_emit_idle, out_strobe && !last && !busy, "emit ended early")
    // error and empty results are always single
    `SIRL_ASSERT(a_err_last, err_out |-> last, "status result not last")
    // insert into a full list reports full on the next cycle
    `SIRL_ASSERT(a_full_drop, ins_full |=> full_out, "full insert not reported")

endmodule

/* rtl/sirl_dpath.sv */
`timescale 1ns / 1ps
module sirl_dpath #(
    parameter int CAPACITY = sirl_pkg::DEF_CAPACITY
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sirl_pkg::dp_cmd_t             cmd,
    input  logic [sirl_pkg::KEY_W-1:0]    sort_key,
    input  logic [sirl_pkg::TAG_W-1:0]    entry_tag,
    output sirl_pkg::dp_sts_t             sts,
    output logic                          out_strobe,
    output logic [sirl_pkg::STATUS_W-1:0] status,
    output logic [sirl_pkg::KEY_W-1:0]    out_key,
    output logic [sirl_pkg::TAG_W-1:0]    out_tag,
    output logic [sirl_pkg::RANK_W-1:0]   rank,
    output logic                          last
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = sirl_pkg::KEY_W;
    localparam int TW = sirl_pkg::TAG_W;
    localparam int EW = sirl_pkg::ENTRY_W;

    logic [EW-1:0] mem [CAPACITY];

    logic [KW-1:0] key_in_reg,   key_in_next;
    logic [TW-1:0] tag_in_reg,   tag_in_next;
    logic [CW-1:0] count_reg,    count_next;
    logic [CW-1:0] lo_reg,       lo_next;
    logic [CW-1:0] hi_reg,       hi_next;
    logic [CW-1:0] idx_reg,      idx_next;
    logic [CW-1:0] rank_reg,     rank_next;
    logic [KW-1:0] prev_key_reg, prev_key_next;
    logic [EW-1:0] rd_data_reg;

    logic                          strobe_reg, strobe_next;
    logic [sirl_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [KW-1:0]                 okey_reg,   okey_next;
    logic [TW-1:0]                 otag_reg,   otag_next;
    logic [sirl_pkg::RANK_W-1:0]   orank_reg,  orank_next;
    logic                          last_reg,   last_next;

    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid;
    logic [CW-1:0] mid_inc;
    logic [CW-1:0] lo_step;
    logic [CW-1:0] hi_step;
    logic [CW-1:0] idx_dec;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] rank_new;
    logic [KW-1:0] rd_key;
    logic [TW-1:0] rd_tag;
    logic          key_above;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    assign rd_key    = rd_data_reg[EW-1:TW];
    assign rd_tag    = rd_data_reg[TW-1:0];
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[CW:1];
    assign mid_inc   = mid + CW'(1);
    assign key_above = key_in_reg > rd_key;
    assign lo_step   = key_above ? lo_reg : mid_inc;
    assign hi_step   = key_above ? mid : hi_reg;
    assign idx_dec   = idx_reg - CW'(1);
    assign idx_inc   = idx_reg + CW'(1);
    assign rank_new  = (idx_reg == CW'(0) || rd_key != prev_key_reg) ? idx_inc : rank_reg;

    assign sts.full     = count_reg == CW'(CAPACITY);
    assign sts.empty    = count_reg == CW'(0);
    assign sts.srch_fin = !(lo_step < hi_step);
    assign sts.sh_more  = idx_reg > lo_reg;
    assign sts.em_last  = idx_inc == count_reg;

    // single read port, single write port
    always_comb
    begin
        rd_en   = cmd.rd_mid | cmd.rd_prev | cmd.rd_idx;
        rd_addr = idx_reg[AW-1:0];
        if (cmd.rd_mid)
        begin
            rd_addr = mid[AW-1:0];
        end
        else if (cmd.rd_prev)
        begin
            rd_addr = idx_dec[AW-1:0];
        end
        wr_en   = cmd.wr_shift | cmd.wr_ins;
        wr_addr = cmd.wr_ins ? lo_reg[AW-1:0] : idx_reg[AW-1:0];
        wr_data = cmd.wr_ins ? {key_in_reg, tag_in_reg} : rd_data_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        key_in_next   = cmd.cap ? sort_key : key_in_reg;
        tag_in_next   = cmd.cap ? entry_tag : tag_in_reg;
        count_next    = count_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        idx_next      = idx_reg;
        rank_next     = rank_reg;
        prev_key_next = prev_key_reg;

        strobe_next = 1'b0;
        status_next = status_reg;
        okey_next   = okey_reg;
        otag_next   = otag_reg;
        orank_next  = orank_reg;
        last_next   = last_reg;

        if (cmd.srch_init)
        begin
            lo_next  = CW'(0);
            hi_next  = count_reg;
            idx_next = count_reg;
        end
        if (cmd.srch_step)
        begin
            lo_next = lo_step;
            hi_next = hi_step;
        end
        if (cmd.wr_shift)
        begin
            idx_next = idx_dec;
        end
        if (cmd.wr_ins)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.clr)
        begin
            count_next = CW'(0);
        end
        if (cmd.em_init)
        begin
            idx_next = CW'(0);
        end
        if (cmd.em_post)
        begin
            idx_next      = idx_inc;
            rank_next     = rank_new;
            prev_key_next = rd_key;
            strobe_next   = 1'b1;
            status_next   = sirl_pkg::ST_OK;
            okey_next     = rd_key;
            otag_next     = rd_tag;
            orank_next    = sirl_pkg::RANK_W'(rank_new);
            last_next     = sts.em_last;
        end
        if (cmd.post_ok || cmd.post_full || cmd.post_empty)
        begin
            strobe_next = 1'b1;
            status_next = sirl_pkg::ST_OK;
            if (cmd.post_full)
            begin
                status_next = sirl_pkg::ST_FULL;
            end
            else if (cmd.post_empty)
            begin
                status_next = sirl_pkg::ST_EMPTY;
            end
            okey_next  = '0;
            otag_next  = '0;
            orank_next = '0;
            last_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_in_reg   <= key_in_next;
        tag_in_reg   <= tag_in_next;
        rank_reg     <= rank_next;
        prev_key_reg <= prev_key_next;
        status_reg   <= status_next;
        okey_reg     <= okey_next;
        otag_reg     <= otag_next;
        orank_reg    <= orank_next;
        last_reg     <= last_next;
    end

    assign out_strobe = strobe_reg;
    assign status     = status_reg;
    assign out_key    = okey_reg;
    assign out_tag    = otag_reg;
    assign rank       = orank_reg;
    assign last       = last_reg;

endmodule

/* rtl/sirl_ctrl.sv */
`timescale 1ns / 1ps
module sirl_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [sirl_pkg::OP_W-1:0] operation,
    input  sirl_pkg::dp_sts_t         sts,
    output logic                      busy,
    output sirl_pkg::dp_cmd_t         cmd
);

    sirl_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sirl_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sirl_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (operation == sirl_pkg::OP_INSERT && !sts.full)
                    begin
                        state_next = sts.empty ? sirl_pkg::S_SHIFT_CHK : sirl_pkg::S_SRCH_RD;
                    end
                    else if (operation == sirl_pkg::OP_EMIT && !sts.empty)
                    begin
                        state_next = sirl_pkg::S_EMIT_RD;
                    end
                end
            end
            sirl_pkg::S_SRCH_RD:   state_next = sirl_pkg::S_SRCH_CMP;
            sirl_pkg::S_SRCH_CMP:
            begin
                state_next = sts.srch_fin ? sirl_pkg::S_SHIFT_CHK : sirl_pkg::S_SRCH_RD;
            end
            sirl_pkg::S_SHIFT_CHK:
            begin
                state_next = sts.sh_more ? sirl_pkg::S_SHIFT_RD : sirl_pkg::S_INS_WR;
            end
            sirl_pkg::S_SHIFT_RD:  state_next = sirl_pkg::S_SHIFT_WR;
            sirl_pkg::S_SHIFT_WR:  state_next = sirl_pkg::S_SHIFT_CHK;
            sirl_pkg::S_INS_WR:    state_next = sirl_pkg::S_IDLE;
            sirl_pkg::S_EMIT_RD:   state_next = sirl_pkg::S_EMIT_OUT;
            sirl_pkg::S_EMIT_OUT:
            begin
                state_next = sts.em_last ? sirl_pkg::S_IDLE : sirl_pkg::S_EMIT_RD;
            end
            default:               state_next = sirl_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            sirl_pkg::S_IDLE:
            begin
                busy    = 1'b0;
                cmd.cap = start;
                if (start)
                begin
                    if (operation == sirl_pkg::OP_INSERT)
                    begin
                        cmd.post_full = sts.full;
                        cmd.srch_init = !sts.full;
                    end
                    else if (operation == sirl_pkg::OP_EMIT)
                    begin
                        cmd.post_empty = sts.empty;
                        cmd.em_init    = !sts.empty;
                    end
                    else if (operation == sirl_pkg::OP_CLEAR)
                    begin
                        cmd.clr     = 1'b1;
                        cmd.post_ok = 1'b1;
                    end
                end
            end
            sirl_pkg::S_SRCH_RD:   cmd.rd_mid    = 1'b1;
            sirl_pkg::S_SRCH_CMP:  cmd.srch_step = 1'b1;
            sirl_pkg::S_SHIFT_CHK: cmd           = '0;
            sirl_pkg::S_SHIFT_RD:  cmd.rd_prev   = 1'b1;
            sirl_pkg::S_SHIFT_WR:  cmd.wr_shift  = 1'b1;
            sirl_pkg::S_INS_WR:
            begin
                cmd.wr_ins  = 1'b1;
                cmd.post_ok = 1'b1;
            end
            sirl_pkg::S_EMIT_RD:   cmd.rd_idx  = 1'b1;
            sirl_pkg::S_EMIT_OUT:  cmd.em_post = 1'b1;
            default:               cmd         = '0;
        endcase
    end

endmodule

/* tb/sorted_insert_rank_list_checker.sv */
`timescale 1ns / 1ps
// Watches the command and result channels, keeps a shadow copy of the
// ranked list and compares every result strobe against the oldest
// predicted result.
module sorted_insert_rank_list_checker #(
    parameter int CAPACITY = sirl_pkg::DEF_CAPACITY
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [sirl_pkg::OP_W-1:0]     operation,
    input  logic [sirl_pkg::KEY_W-1:0]    sort_key,
    input  logic [sirl_pkg::TAG_W-1:0]    entry_tag,
    input  logic                          out_strobe,
    input  logic [sirl_pkg::STATUS_W-1:0] status,
    input  logic [sirl_pkg::KEY_W-1:0]    out_key,
    input  logic [sirl_pkg::TAG_W-1:0]    out_tag,
    input  logic [sirl_pkg::RANK_W-1:0]   rank,
    input  logic                          last,
    output int                            pending,
    output int                            errors
);
    import sirl_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    key;
        logic [TAG_W-1:0]    tag;
        logic [RANK_W-1:0]   rank;
        logic                last;
    } rank_result_t;

    logic [KEY_W-1:0] shadow_key [CAPACITY];
    logic [TAG_W-1:0] shadow_tag [CAPACITY];
    int               shadow_count = 0;
    rank_result_t     ranked_q[$];
    rank_result_t     head;

    function automatic rank_result_t make_result(input logic [STATUS_W-1:0] st,
                                                 input logic [KEY_W-1:0] k,
                                                 input logic [TAG_W-1:0] t,
                                                 input int r,
                                                 input logic l);
        rank_result_t res;
        res.status = st;
        res.key    = k;
        res.tag    = t;
        res.rank   = RANK_W'(r);
        res.last   = l;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("%0t ns: %s", $time, msg);
    endtask

    // Apply one accepted command to the shadow list and queue its results.
    task automatic predict_ranked(input logic [OP_W-1:0] op,
                                  input logic [KEY_W-1:0] k,
                                  input logic [TAG_W-1:0] t);
        int lo;
        int hi;
        int mid;
        int pos;
        int cur_rank;
        case (op)
            OP_INSERT:
            begin
                if (shadow_count >= CAPACITY)
                    ranked_q.push_back(make_result(ST_FULL, '0, '0, 0, 1'b1));
                else
                begin
                    // upper-bound search: new key lands after equal keys
                    lo = 0;
                    hi = shadow_count;
                    while (lo < hi)
                    begin
                        mid = lo + (hi - lo) / 2;
                        if (k > shadow_key[mid])
                            hi = mid;
                        else
                            lo = mid + 1;
                    end
                    for (pos = shadow_count; pos > lo; pos--)
                    begin
                        shadow_key[pos] = shadow_key[pos-1];
                        shadow_tag[pos] = shadow_tag[pos-1];
                    end
                    shadow_key[lo] = k;
                    shadow_tag[lo] = t;
                    shadow_count++;
                    ranked_q.push_back(make_result(ST_OK, '0, '0, 0, 1'b1));
                end
            end
            OP_EMIT:
            begin
                if (shadow_count == 0)
                    ranked_q.push_back(make_result(ST_EMPTY, '0, '0, 0, 1'b1));
                else
                begin
                    cur_rank = 1;
                    for (pos = 0; pos < shadow_count; pos++)
                    begin
                        if (pos > 0 && shadow_key[pos] != shadow_key[pos-1])
                            cur_rank = pos + 1;
                        ranked_q.push_back(make_result(ST_OK, shadow_key[pos],
                                                       shadow_tag[pos], cur_rank,
                                                       pos + 1 == shadow_count));
                    end
                end
            end
            OP_CLEAR:
            begin
                shadow_count = 0;
                ranked_q.push_back(make_result(ST_OK, '0, '0, 0, 1'b1));
            end
            default:
            begin
                // unused code: no state change, no result
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_count = 0;
            ranked_q.delete();
            pending = 0;
            errors  = 0;
        end
        else
        begin
            // results first: a command never answers in its own accept cycle
            if (out_strobe)
            begin
                if (ranked_q.size() == 0)
                    report_mismatch($sformatf("unexpected result: status %0d key %0d tag %0d",
                                              status, out_key, out_tag));
                else
                begin
                    head = ranked_q.pop_front();
                    if (status !== head.status)
                        report_mismatch($sformatf("status: expected %0d, got %0d",
                                                  head.status, status));
                    if (out_key !== head.key)
                        report_mismatch($sformatf("out_key: expected %0d, got %0d",
                                                  head.key, out_key));
                    if (out_tag !== head.tag)
                        report_mismatch($sformatf("out_tag: expected %0d, got %0d",
                                                  head.tag, out_tag));
                    if (rank !== head.rank)
                        report_mismatch($sformatf("rank: expected %0d, got %0d",
                                                  head.rank, rank));
                    if (last !== head.last)
                        report_mismatch($sformatf("last: expected %0d, got %0d",
                                                  head.last, last));
                end
            end
            if (start && !busy)
                predict_ranked(operation, sort_key, entry_tag);
            pending = ranked_q.size();
        end
    end

endmodule

/* tb/sorted_insert_rank_list_tb.sv */
`timescale 1ns / 1ps
// Top of the rank list bench: clock, reset, command stimulus and verdict.
// All prediction and comparison lives in the checker instance.
module sorted_insert_rank_list_tb;
    import sirl_pkg::*;

    localparam int CAPACITY = DEF_CAPACITY;

    // code 3 is not an operation; the block must ignore it
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int ITEM_TARGET   = 380;
    // an insert into a nearly full list is the slowest command (a check, a read and
    // a write per shifted entry plus the search), so this covers any stray strobe
    localparam int SETTLE_CYCLES = 4 * CAPACITY;

    // key choice per list: fully random, clustered for ties, or only extremes
    typedef enum int {
        KEYS_ANY,
        KEYS_CLUSTER,
        KEYS_EXTREME
    } key_mode_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                start      = 1'b0;
    logic [OP_W-1:0]     operation  = OP_INSERT;
    logic [KEY_W-1:0]    sort_key   = '0;
    logic [TAG_W-1:0]    entry_tag  = '0;
    logic                busy;
    logic                out_strobe;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    out_key;
    logic [TAG_W-1:0]    out_tag;
    logic [RANK_W-1:0]   rank;
    logic                last;

    int                  pending;      // results still owed, from the checker
    int                  errors;       // mismatch count, from the checker
    int                  items_sent = 0;
    bit                  no_idle    = 1'b0;
    logic [KEY_W-1:0]    key_base   = '0;
    int                  pick;

    sorted_insert_rank_list #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .sort_key   (sort_key),
        .entry_tag  (entry_tag),
        .out_strobe (out_strobe),
        .status     (status),
        .out_key    (out_key),
        .out_tag    (out_tag),
        .rank       (rank),
        .last       (last)
    );

    sorted_insert_rank_list_checker #(
        .CAPACITY (CAPACITY)
    ) rank_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .sort_key   (sort_key),
        .entry_tag  (entry_tag),
        .out_strobe (out_strobe),
        .status     (status),
        .out_key    (out_key),
        .out_tag    (out_tag),
        .rank       (rank),
        .last       (last),
        .pending    (pending),
        .errors     (errors)
    );

    always #1 clk = ~clk;

    // Mostly back-to-back or short gaps, now and then a long one. Inside a
    // no-idle stretch the sender keeps start high throughout.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key(input key_mode_t mode);
        case (mode)
            KEYS_CLUSTER: return key_base + KEY_W'($urandom_range(0, 3));
            KEYS_EXTREME: return ($urandom_range(0, 1) == 1) ? '1 : '0;
            default:      return KEY_W'($urandom);
        endcase
    endfunction

    // One command transfer. Start is lowered only when a gap is taken, so
    // back-to-back commands keep it high with a single assignment per step.
    task automatic send(input logic [OP_W-1:0] op,
                        input logic [KEY_W-1:0] k,
                        input logic [TAG_W-1:0] t);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        sort_key  <= k;
        entry_tag <= t;
        // busy read here is the value the block saw at this edge
        do
            @(posedge clk);
        while (busy);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    // Hold off the sender until every owed result has come back. Pending is
    // sampled on the falling edge, after the checker has settled.
    task automatic drain_results();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    // Random command with random fields: inserts, emits and clears in the middle of
    // a list, and the unused code.
    task automatic send_noise();
        send(OP_W'($urandom_range(0, 3)), KEY_W'($urandom),
             TAG_W'($urandom_range(0, 16'hFFFF)));
    endtask

    // Fill to capacity, push a few more that must be dropped as full, then
    // emit the whole list (64 ranked results).
    task automatic fill_list();
        key_mode_t mode;
        mode     = key_mode_t'($urandom_range(0, 2));
        key_base = KEY_W'($urandom);
        send(OP_CLEAR, KEY_W'($urandom), TAG_W'($urandom_range(0, 16'hFFFF)));
        repeat (CAPACITY + $urandom_range(1, 3))
            send(OP_INSERT, pick_key(mode), TAG_W'($urandom_range(0, 16'hFFFF)));
        send(OP_EMIT, KEY_W'($urandom), TAG_W'($urandom_range(0, 16'hFFFF)));
    endtask

    // Typical use: clear, a short run of inserts, emit. Sometimes the clear is
    // skipped so lists grow across episodes, and noise is mixed in.
    task automatic list_episode();
        int        n;
        key_mode_t mode;
        n        = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 10)
                                                : $urandom_range(11, 40);
        mode     = key_mode_t'($urandom_range(0, 2));
        key_base = KEY_W'($urandom);
        if ($urandom_range(0, 4) != 0)
            send(OP_CLEAR, KEY_W'($urandom), TAG_W'($urandom_range(0, 16'hFFFF)));
        repeat (n)
        begin
            if ($urandom_range(0, 19) == 0)
                send_noise();
            else
                send(OP_INSERT, pick_key(mode), TAG_W'($urandom_range(0, 16'hFFFF)));
        end
        send(OP_EMIT, KEY_W'($urandom), TAG_W'($urandom_range(0, 16'hFFFF)));
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty list cases, ignored code, field extremes, ties at
        // the head, the tail and the middle, single-entry emit.
        send(OP_EMIT,   8'h00, 16'h0000);   // emit of an empty list
        send(OP_CLEAR,  8'hFF, 16'hFFFF);   // clear of an empty list
        send(OP_UNUSED, 8'hA5, 16'h5AA5);   // ignored, no result
        send(OP_INSERT, 8'h01, 16'h00FF);
        send(OP_EMIT,   8'hFF, 16'hFFFF);   // one entry: rank 1, last set
        send(OP_INSERT, 8'h00, 16'h0000);
        send(OP_INSERT, 8'hFF, 16'hFFFF);
        send(OP_INSERT, 8'hFF, 16'h0001);   // tie at the head goes second
        send(OP_INSERT, 8'h00, 16'h8000);   // tie at the tail goes last
        send(OP_INSERT, 8'h80, 16'h5555);
        send(OP_INSERT, 8'h7F, 16'hAAAA);
        send(OP_UNUSED, 8'hFF, 16'hFFFF);
        send(OP_EMIT,   8'h00, 16'h0000);
        send(OP_INSERT, 8'h80, 16'h1234);   // tie in the middle
        send(OP_INSERT, 8'h80, 16'hFEDC);
        send(OP_EMIT,   8'h12, 16'h3456);
        send(OP_CLEAR,  8'h00, 16'h0000);
        send(OP_EMIT,   8'h00, 16'h0000);   // empty again after clear
        send(OP_INSERT, 8'h42, 16'hBEEF);
        send(OP_EMIT,   8'h00, 16'h0000);

        // at least one full list with dropped inserts, then a full pause
        fill_list();
        drain_results();

        // Random episodes until the item budget is spent
        while (items_sent < ITEM_TARGET)
        begin
            no_idle = ($urandom_range(0, 5) == 0);
            pick    = $urandom_range(0, 29);
            if (pick == 0)
                fill_list();
            else if (pick < 4)
            begin
                repeat ($urandom_range(1, 4))
                    send_noise();
            end
            else
                list_episode();
            if ($urandom_range(0, 9) == 0)
                drain_results();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog: several times the slowest legal run
    initial
    begin
        #1000000;
        $display("timeout with %0d results still owed", pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sorted_insert_rank_list.f */
+incdir+rtl
rtl/sirl_pkg.sv
rtl/sirl_dpath.sv
rtl/sirl_ctrl.sv
rtl/sorted_insert_rank_list.sv
tb/sorted_insert_rank_list_checker.sv
tb/sorted_insert_rank_list_tb.sv
